// ===== sv/sorted_list_binary_search_assert.svh =====
// assertion macros used by the port-level checker of the sorted list search block
`ifndef SORTED_LIST_BINARY_SEARCH_ASSERT_SVH
`define SORTED_LIST_BINARY_SEARCH_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SLBS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define SLBS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/slbs_pkg.sv =====
// shared types, codes and constants of the sorted list search block
package slbs_pkg;

	// default sizing
	localparam int DEPTH_DEF     = 16;
	localparam int WORD_BITS_DEF = 32;

	// fixed field widths
	localparam int VALUE_W  = 32;
	localparam int ACTION_W = 2;
	localparam int CAP_W    = 5;
	localparam int IDX_W    = 4;
	localparam int HALV_W   = 3;

	// capacity register reset and the value that zero selects
	localparam logic [CAP_W-1:0] CAP_RESET   = 5'd10;
	localparam logic [CAP_W-1:0] CAP_DEFAULT = 5'd10;

	// action codes
	typedef enum logic [ACTION_W-1:0] {
		ACT_APPEND = 2'd0,
		ACT_SORT   = 2'd1,
		ACT_SEARCH = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic append;
		logic sort_init;
		logic rd_i;
		logic load_a;
		logic rd_j;
		logic cmp_j;
		logic wb_i;
		logic srch_init;
		logic rd_mid;
		logic srch_step;
		logic publish;
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic n_zero;
		logic n_le1;
		logic last_j;
		logic last_i;
		logic key_hit;
		logic srch_last;
		logic out_free;
	} sts_t;

endpackage

// ===== sv/slbs_if.sv =====
// valid/ready channel interfaces for request and response transfers
interface slbs_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [slbs_pkg::ACTION_W-1:0]        action;
	logic signed [slbs_pkg::VALUE_W-1:0]  value;

	modport source (output valid, output action, output value, input ready);
	modport sink (input valid, input action, input value, output ready);
endinterface

interface slbs_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          status;
	logic                          found;
	logic [slbs_pkg::IDX_W-1:0]    match_index;
	logic [slbs_pkg::HALV_W-1:0]   halvings;

	modport source (output valid, output status, output found, output match_index,
		output halvings, input ready);
	modport sink (input valid, input status, input found, input match_index,
		input halvings, output ready);
endinterface

// ===== sv/slbs_dp.sv =====
// datapath: entry memory, count, capacity, sort and search registers, result register
module slbs_dp #(
	parameter int DEPTH     = slbs_pkg::DEPTH_DEF,
	parameter int WORD_BITS = slbs_pkg::WORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [slbs_pkg::CAP_W-1:0]           cfg_wdata,
	input  logic signed [slbs_pkg::VALUE_W-1:0]  req_value,
	input  slbs_pkg::cmd_t                       cmd,
	output slbs_pkg::sts_t                       sts,
	input  logic                                 rsp_ready,
	output logic                                 rsp_valid,
	output logic                                 rsp_status,
	output logic                                 rsp_found,
	output logic [slbs_pkg::IDX_W-1:0]           rsp_match_index,
	output logic [slbs_pkg::HALV_W-1:0]          rsp_halvings
);

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > slbs_pkg::CAP_W) ? CW : slbs_pkg::CAP_W;

	logic signed [WORD_BITS-1:0] mem [DEPTH];

	logic [slbs_pkg::CAP_W-1:0]  capacity_q;
	logic [CW-1:0]               count_q;
	logic signed [WORD_BITS-1:0] key_q;
	logic signed [WORD_BITS-1:0] a_q;
	logic signed [WORD_BITS-1:0] rd_data_q;
	logic [AW-1:0]               i_q;
	logic [AW-1:0]               j_q;
	logic [CW-1:0]               lo_q;
	logic [CW-1:0]               hi_q;
	logic [slbs_pkg::HALV_W-1:0] cnt_q;
	logic                        pend_status_q;
	logic                        pend_found_q;
	logic [slbs_pkg::IDX_W-1:0]  pend_idx_q;
	logic [slbs_pkg::HALV_W-1:0] pend_halv_q;
	logic                        rsp_valid_q;
	logic                        rsp_status_q;
	logic                        rsp_found_q;
	logic [slbs_pkg::IDX_W-1:0]  rsp_idx_q;
	logic [slbs_pkg::HALV_W-1:0] rsp_halv_q;

	logic [slbs_pkg::CAP_W-1:0]  cap_sel;
	logic                        list_full;
	logic [CW:0]                 mid_sum;
	logic [CW-1:0]               mid_full;
	logic [AW-1:0]               mid;
	logic                        key_gt;
	logic                        swap;
	logic [CW-1:0]               lo_nx;
	logic [CW-1:0]               hi_nx;
	logic                        rd_en;
	logic [AW-1:0]               rd_addr;
	logic                        wr_en;
	logic [AW-1:0]               wr_addr;
	logic signed [WORD_BITS-1:0] wr_data;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= slbs_pkg::CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	// effective capacity, saturated at the depth
	assign cap_sel   = (capacity_q == '0) ? slbs_pkg::CAP_DEFAULT : capacity_q;
	assign list_full = (CMPW'(count_q) >= CMPW'(cap_sel)) || (count_q == CW'(DEPTH));

	// search probe position and interval update
	assign mid_sum  = (CW+1)'(lo_q) + (CW+1)'(hi_q) - (CW+1)'(1);
	assign mid_full = mid_sum[CW:1];
	assign mid      = mid_full[AW-1:0];
	assign key_gt   = key_q > rd_data_q;
	assign lo_nx    = key_gt ? (CW'(mid) + CW'(1)) : lo_q;
	assign hi_nx    = key_gt ? hi_q : CW'(mid);

	// exchange when the later entry is smaller
	assign swap = rd_data_q < a_q;

	// status to the controller
	assign sts.n_zero    = (count_q == '0);
	assign sts.n_le1     = (count_q <= CW'(1));
	assign sts.last_j    = ((CW'(j_q) + CW'(1)) == count_q);
	assign sts.last_i    = ((CW'(i_q) + CW'(2)) >= count_q);
	assign sts.key_hit   = (rd_data_q == key_q);
	assign sts.srch_last = (lo_nx >= hi_nx);
	assign sts.out_free  = !rsp_valid_q || rsp_ready;

	// memory port selection
	always_comb begin
		rd_en   = cmd.rd_i || cmd.rd_j || cmd.rd_mid;
		rd_addr = mid;
		if (cmd.rd_i) begin
			rd_addr = i_q;
		end else if (cmd.rd_j) begin
			rd_addr = j_q;
		end
		wr_en   = 1'b0;
		wr_addr = i_q;
		wr_data = a_q;
		if (cmd.append && !list_full) begin
			wr_en   = 1'b1;
			wr_addr = count_q[AW-1:0];
			wr_data = key_q;
		end else if (cmd.cmp_j && swap) begin
			wr_en   = 1'b1;
			wr_addr = j_q;
		end else if (cmd.wb_i) begin
			wr_en   = 1'b1;
		end
	end

	// entry memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.append && !list_full) begin
			count_q <= count_q + CW'(1);
		end
	end

	// working registers of the current item
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			key_q         <= WORD_BITS'(req_value);
			pend_status_q <= 1'b0;
			pend_found_q  <= 1'b0;
			pend_idx_q    <= '0;
			pend_halv_q   <= '0;
		end
		if (cmd.append && list_full) begin
			pend_status_q <= 1'b1;
		end
		if (cmd.sort_init) begin
			i_q <= '0;
		end
		if (cmd.load_a) begin
			a_q <= rd_data_q;
			j_q <= i_q + AW'(1);
		end
		if (cmd.cmp_j) begin
			if (swap) begin
				a_q <= rd_data_q;
			end
			j_q <= j_q + AW'(1);
		end
		if (cmd.wb_i) begin
			i_q <= i_q + AW'(1);
		end
		if (cmd.srch_init) begin
			lo_q  <= '0;
			hi_q  <= count_q;
			cnt_q <= '0;
		end
		if (cmd.srch_step) begin
			if (sts.key_hit) begin
				pend_found_q <= 1'b1;
				pend_idx_q   <= slbs_pkg::IDX_W'(mid);
				pend_halv_q  <= cnt_q;
			end else begin
				lo_q  <= lo_nx;
				hi_q  <= hi_nx;
				cnt_q <= cnt_q + slbs_pkg::HALV_W'(1);
			end
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			rsp_status_q <= pend_status_q;
			rsp_found_q  <= pend_found_q;
			rsp_idx_q    <= pend_idx_q;
			rsp_halv_q   <= pend_halv_q;
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign rsp_status      = rsp_status_q;
	assign rsp_found       = rsp_found_q;
	assign rsp_match_index = rsp_idx_q;
	assign rsp_halvings    = rsp_halv_q;

endmodule

// ===== sv/slbs_ctrl.sv =====
// controller: state machine sequencing append, sort and search over the datapath
module slbs_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	input  logic [slbs_pkg::ACTION_W-1:0]  req_action,
	output logic                           req_ready,
	input  slbs_pkg::sts_t                 sts,
	output slbs_pkg::cmd_t                 cmd
);

	typedef enum logic [9:0] {
		ST_IDLE     = 10'b00_0000_0001,
		ST_APPEND   = 10'b00_0000_0010,
		ST_SORT_RI  = 10'b00_0000_0100,
		ST_SORT_LA  = 10'b00_0000_1000,
		ST_SORT_RJ  = 10'b00_0001_0000,
		ST_SORT_CJ  = 10'b00_0010_0000,
		ST_SORT_WB  = 10'b00_0100_0000,
		ST_SRCH_RD  = 10'b00_1000_0000,
		ST_SRCH_CMP = 10'b01_0000_0000,
		ST_DONE     = 10'b10_0000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign req_ready = (state_q == ST_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					unique case (slbs_pkg::action_t'(req_action))
						slbs_pkg::ACT_APPEND: begin
							state_d = ST_APPEND;
						end
						slbs_pkg::ACT_SORT: begin
							if (sts.n_le1) begin
								state_d = ST_DONE;
							end else begin
								cmd.sort_init = 1'b1;
								state_d       = ST_SORT_RI;
							end
						end
						slbs_pkg::ACT_SEARCH: begin
							if (sts.n_zero) begin
								state_d = ST_DONE;
							end else begin
								cmd.srch_init = 1'b1;
								state_d       = ST_SRCH_RD;
							end
						end
						slbs_pkg::ACT_NONE: begin
							state_d = ST_DONE;
						end
					endcase
				end
			end
			ST_APPEND: begin
				cmd.append = 1'b1;
				state_d    = ST_DONE;
			end
			// outer pass: fetch the entry at position i
			ST_SORT_RI: begin
				cmd.rd_i = 1'b1;
				state_d  = ST_SORT_LA;
			end
			ST_SORT_LA: begin
				cmd.load_a = 1'b1;
				state_d    = ST_SORT_RJ;
			end
			// inner pass: compare each later entry with the held one
			ST_SORT_RJ: begin
				cmd.rd_j = 1'b1;
				state_d  = ST_SORT_CJ;
			end
			ST_SORT_CJ: begin
				cmd.cmp_j = 1'b1;
				state_d   = sts.last_j ? ST_SORT_WB : ST_SORT_RJ;
			end
			ST_SORT_WB: begin
				cmd.wb_i = 1'b1;
				state_d  = sts.last_i ? ST_DONE : ST_SORT_RI;
			end
			// binary search probe
			ST_SRCH_RD: begin
				cmd.rd_mid = 1'b1;
				state_d    = ST_SRCH_CMP;
			end
			ST_SRCH_CMP: begin
				cmd.srch_step = 1'b1;
				state_d       = (sts.key_hit || sts.srch_last) ? ST_DONE : ST_SRCH_RD;
			end
			// hand the result to the output register once it is free
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/sorted_list_binary_search.sv =====
// Sorted list store of signed words with append, exchange sort and binary search. One request
// is worked at a time and every request gives one response; a new request is taken while the
// previous response still waits in the output register. A request is taken in the idle state
// and its result handed over once the output register is free. A sort over n entries holds
// each entry in turn, reads and compares each later entry against it, then writes it back;
// a search reads and compares one probe at a time, at most floor(log2 n) + 1 probes. Every
// compare waits for its operand from the registered memory read. The user must write the
// capacity register through cfg_we/cfg_wdata only while idle; the block does not enforce it.
module sorted_list_binary_search #(
	parameter int DEPTH     = slbs_pkg::DEPTH_DEF,
	parameter int WORD_BITS = slbs_pkg::WORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [slbs_pkg::CAP_W-1:0]  cfg_wdata,
	slbs_req_if.sink                    req,
	slbs_rsp_if.source                  rsp
);

	slbs_pkg::cmd_t cmd;
	slbs_pkg::sts_t sts;

	// controller
	slbs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_action (req.action),
		.req_ready  (req.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	// datapath
	slbs_dp #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.req_value       (req.value),
		.cmd             (cmd),
		.sts             (sts),
		.rsp_ready       (rsp.ready),
		.rsp_valid       (rsp.valid),
		.rsp_status      (rsp.status),
		.rsp_found       (rsp.found),
		.rsp_match_index (rsp.match_index),
		.rsp_halvings    (rsp.halvings)
	);

endmodule

// ===== sv/slbs_chk.sv =====
// port-level checker for the sorted list search block, with its bind
`include "sorted_list_binary_search_assert.svh"

module slbs_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic                          status,
	input logic                          found,
	input logic [slbs_pkg::IDX_W-1:0]    match_index,
	input logic [slbs_pkg::HALV_W-1:0]   halvings
);

	// a stalled response keeps its payload
	`SLBS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable({status, found, match_index, halvings}), "response changed while stalled")

	// one request in work at a time
	`SLBS_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "request taken while busy")

	// a miss carries no position or halving count
	`SLBS_ASSERT_NOW(a_miss_zero, rsp_valid && !found, match_index == '0 && halvings == '0, "miss with nonzero index")

	// a refused append is never a search hit
	`SLBS_ASSERT_NOW(a_full_not_found, rsp_valid && status, !found, "full status together with found")

endmodule

bind sorted_list_binary_search slbs_chk u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.status      (rsp.status),
	.found       (rsp.found),
	.match_index (rsp.match_index),
	.halvings    (rsp.halvings)
);

// ===== dv/slbs_checker.sv =====
// checker for the sorted list search block: predicts each response and compares it
module slbs_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [slbs_pkg::CAP_W-1:0] cfg_wdata,
	slbs_req_if                        req,
	slbs_rsp_if                        rsp,
	output int                         fail_count,
	output int                         outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import slbs_pkg::*;

	// one response as the block should give it
	typedef struct packed {
		logic              status;
		logic              found;
		logic [IDX_W-1:0]  match_index;
		logic [HALV_W-1:0] halvings;
	} outcome_t;

	// shadow of the stored list and of the capacity register
	logic signed [VALUE_W-1:0] list_mem [DEPTH_DEF];
	int                        list_len;
	logic [CAP_W-1:0]          capacity;
	outcome_t                  expected_q [$];

	// capacity in force: zero selects the default, never above the depth
	function automatic int cap_limit();
		int c;
		c = (capacity == '0) ? int'(CAP_DEFAULT) : int'(capacity);
		return (c > DEPTH_DEF) ? DEPTH_DEF : c;
	endfunction

	// applies one request to the shadow list and returns its response
	function automatic outcome_t run_action(input action_t act,
		input logic signed [VALUE_W-1:0] v);
		outcome_t                  res;
		int                        i;
		int                        j;
		int                        lo;
		int                        hi;
		int                        mid;
		int                        probes;
		logic signed [VALUE_W-1:0] tmp;
		res = '0;
		case (act)
			ACT_APPEND: begin
				if (list_len >= cap_limit()) begin
					res.status = 1'b1;
				end else begin
					list_mem[list_len] = v;
					list_len++;
				end
			end
			ACT_SORT: begin
				// exchange sort: each position against every later one
				for (i = 0; i < list_len - 1; i++) begin
					for (j = i + 1; j < list_len; j++) begin
						if (list_mem[j] < list_mem[i]) begin
							tmp = list_mem[j];
							list_mem[j] = list_mem[i];
							list_mem[i] = tmp;
						end
					end
				end
			end
			ACT_SEARCH: begin
				// binary search, counting halvings until the hit
				lo = 0;
				hi = list_len - 1;
				probes = 0;
				while (lo <= hi) begin
					mid = (lo + hi) / 2;
					if (v > list_mem[mid]) begin
						lo = mid + 1;
						probes++;
					end else if (v < list_mem[mid]) begin
						hi = mid - 1;
						probes++;
					end else begin
						res.found = 1'b1;
						res.match_index = mid[IDX_W-1:0];
						res.halvings = probes[HALV_W-1:0];
						break;
					end
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	// track config writes, predict on request transfers, compare on response transfers
	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			list_len = 0;
			capacity = CAP_RESET;
			expected_q.delete();
			fail_count = 0;
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				capacity = cfg_wdata;
			end
			if (req.valid && req.ready) begin
				expected_q.push_back(run_action(action_t'(req.action), req.value));
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0) begin
					$error("response transfer with no request outstanding");
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					check_field("status", want.status, rsp.status);
					check_field("found", want.found, rsp.found);
					check_field("match_index", want.match_index, rsp.match_index);
					check_field("halvings", want.halvings, rsp.halvings);
				end
			end
			outstanding = expected_q.size();
		end
	end

endmodule

// ===== dv/tb.sv =====
// top of the sorted list search testbench: clock, reset, stimulus and verdict
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import slbs_pkg::*;

	localparam int GAP_MAX      = 18;
	localparam int RANDOM_ITEMS = 1050;
	localparam int STALL_AT     = 300;
	localparam int STALL_CYCLES = 400;
	localparam int DRAIN_CYCLES = 300;
	localparam int CYCLE_LIMIT  = 1_500_000;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_wdata;

	int  fail_count;
	int  outstanding;
	int  n_req = 0;
	int  n_rsp = 0;
	int  cycles = 0;
	bit  src_idle = 1'b1;
	bit  snk_idle = 1'b1;
	int  snk_gap = 0;

	// stimulus-side view of what is stored, used to aim search keys
	logic [CAP_W-1:0]          cur_cap = CAP_RESET;
	logic signed [VALUE_W-1:0] kept [$];
	logic signed [VALUE_W-1:0] corners [4] = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sd1};

	slbs_req_if req_ch ();
	slbs_rsp_if rsp_ch ();

	sorted_list_binary_search DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	slbs_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("sorted_list_binary_search regression: fail");
				$finish;
			end
		end
	end

	// true while an append would still be stored
	function automatic bit room_left();
		int c;
		c = (cur_cap == '0) ? int'(CAP_DEFAULT) : int'(cur_cap);
		if (c > DEPTH_DEF) begin
			c = DEPTH_DEF;
		end
		return kept.size() < c;
	endfunction

	// offers one request after a random gap and waits for its transfer
	task automatic send_item(input action_t act, input logic signed [VALUE_W-1:0] v);
		int gap;
		if ($urandom_range(0, 39) == 0) begin
			src_idle = !src_idle;
		end
		gap = src_idle ? $urandom_range(0, GAP_MAX) : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= act;
		req_ch.value <= v;
		do @(posedge clk); while (!req_ch.ready);
		n_req++;
		if (act == ACT_APPEND && room_left()) begin
			kept.push_back(v);
		end
	endtask

	// capacity write once every response is back
	task automatic write_capacity(input logic [CAP_W-1:0] c);
		req_ch.valid <= 1'b0;
		while (n_rsp != n_req) @(negedge clk);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_cap = c;
	endtask

	// response side: random stalls, one long hold-off to back up the block
	initial begin
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				n_rsp++;
				if ($urandom_range(0, 39) == 0) begin
					snk_idle = !snk_idle;
				end
				if (n_rsp == STALL_AT) begin
					snk_gap = STALL_CYCLES;
				end else begin
					snk_gap = snk_idle ? $urandom_range(0, GAP_MAX) : 0;
				end
			end else if (!rsp_ch.ready && snk_gap > 0) begin
				snk_gap--;
			end
			rsp_ch.ready <= (snk_gap == 0);
		end
	end

	// reset, directed cases, random phases, verdict
	initial begin
		logic [CAP_W-1:0]          phase_caps [6] = '{5'd0, 5'd12, 5'd1, 5'd16, 5'd31, 5'd7};
		logic signed [VALUE_W-1:0] v;
		action_t                   act;
		int                        done;
		int                        phase;
		int                        r;
		int                        pick;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.action <= ACT_NONE;
		req_ch.value <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list, unused action code
		send_item(ACT_SEARCH, 32'sh0);
		send_item(ACT_SORT, -32'sd1);
		send_item(ACT_NONE, 32'sh7fff_ffff);
		// search on an unsorted list can miss a present key
		send_item(ACT_APPEND, 32'sh7fff_ffff);
		send_item(ACT_APPEND, 32'sh8000_0000);
		send_item(ACT_SEARCH, 32'sh8000_0000);
		send_item(ACT_SORT, 32'sh0);
		send_item(ACT_SEARCH, 32'sh8000_0000);
		send_item(ACT_SEARCH, 32'sh7fff_ffff);
		// duplicates and alternating bit patterns
		send_item(ACT_APPEND, 32'sh0);
		send_item(ACT_APPEND, -32'sd1);
		send_item(ACT_APPEND, 32'sh0);
		send_item(ACT_APPEND, 32'sh5555_5555);
		send_item(ACT_APPEND, 32'shaaaa_aaaa);
		send_item(ACT_SORT, 32'sh0);
		send_item(ACT_SEARCH, 32'sh0);
		send_item(ACT_SEARCH, -32'sd1);
		send_item(ACT_SEARCH, 32'sh5555_5555);
		send_item(ACT_SEARCH, 32'shaaaa_aaaa);
		send_item(ACT_SEARCH, 32'sh7);
		send_item(ACT_SEARCH, 32'sh7fff_ffff);
		// capacity lowered below the count: appends refused, entries kept
		write_capacity(5'd3);
		send_item(ACT_APPEND, 32'sh1);
		send_item(ACT_SEARCH, 32'sh1);
		send_item(ACT_NONE, 32'sh0);

		// random phases, each under its own capacity
		done = 0;
		phase = 0;
		while (done < RANDOM_ITEMS) begin
			write_capacity(phase < 6 ? phase_caps[phase] : CAP_W'($urandom_range(0, 31)));
			repeat ($urandom_range(30, 90)) begin
				r = $urandom_range(0, 99);
				pick = $urandom_range(0, 9);
				v = $urandom;
				if (r < 30) begin
					act = ACT_APPEND;
					if (pick < 2) begin
						v = int'($urandom_range(0, 8)) - 4;
					end else if (pick < 4) begin
						v = corners[$urandom_range(0, 3)];
					end else if (pick < 6 && kept.size() > 0) begin
						v = kept[$urandom_range(0, kept.size() - 1)];
					end
				end else if (r < 45) begin
					act = ACT_SORT;
				end else if (r < 95) begin
					act = ACT_SEARCH;
					if (kept.size() > 0 && pick < 6) begin
						v = kept[$urandom_range(0, kept.size() - 1)];
					end else if (kept.size() > 0 && pick < 7) begin
						v = kept[$urandom_range(0, kept.size() - 1)] + 1;
					end else if (pick < 8) begin
						v = corners[$urandom_range(0, 3)];
					end
				end else begin
					act = ACT_NONE;
				end
				send_item(act, v);
				done++;
			end
			phase++;
		end

		// drain
		req_ch.valid <= 1'b0;
		while (n_rsp != n_req) @(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("sorted_list_binary_search regression: pass");
		end else begin
			$display("sorted_list_binary_search regression: fail");
		end
		$finish;
	end

endmodule
